// File: rtl/bdds_pkg.sv
// ---------------------------------------------------------------------------
// bdds_pkg
// shared types and constants for the base-d digit splitter
// ---------------------------------------------------------------------------
package bdds_pkg;

	localparam int RADIX_W    = 9;
	localparam int DIGIT_W    = 8;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

	// radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 9'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;

	// token handed from one digit cell to the next
	typedef struct packed {
		logic vld;   // a conversion step is present
		logic first; // first step of a value: the cell starts from zero
		logic last;  // final step of a value
		logic carry; // carry into the next more significant digit
	} tok_t;

endpackage

// File: rtl/bdds_cell.sv
// ---------------------------------------------------------------------------
// bdds_cell
// one base-d digit: doubles itself, adds the carry in, reduces by the radix
// ---------------------------------------------------------------------------
module bdds_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [bdds_pkg::RADIX_W-1:0]       radix,
	input  bdds_pkg::tok_t                     tok_in,
	output bdds_pkg::tok_t                     tok_out,
	output logic [bdds_pkg::DIGIT_W-1:0]       digit
);

	logic [bdds_pkg::DIGIT_W-1:0] digit_q;
	logic [bdds_pkg::DIGIT_W-1:0] base;
	logic [bdds_pkg::RADIX_W-1:0] dbl;
	logic [bdds_pkg::RADIX_W-1:0] red;
	logic                         ge;
	bdds_pkg::tok_t               tok_q;

	// digit stays below radix, so 2*digit+1 is below 2*radix: one subtract
	always_comb begin
		base = tok_in.first ? '0 : digit_q;
		dbl  = {base, tok_in.carry};
		ge   = (dbl >= radix);
		red  = ge ? (dbl - radix) : dbl;
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			digit_q <= red[bdds_pkg::DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld   <= tok_in.vld;
			tok_q.first <= tok_in.first;
			tok_q.last  <= tok_in.last;
			tok_q.carry <= tok_in.vld & ge;
		end
	end

	assign tok_out = tok_q;
	assign digit   = digit_q;

endmodule

// File: rtl/base_d_digit_split.sv
// ---------------------------------------------------------------------------
// base_d_digit_split
// splits an unsigned value into a configured number of base-d digits
// ---------------------------------------------------------------------------
// A value enters on the item channel and leaves as digit_count results on the
// result channel, most significant digit first, with last_digit on the final
// one. The conversion runs in a row of MAX_DIGITS digit cells, least
// significant digit in cell 0. The value is shifted in one bit per cycle,
// most significant bit first; each cell doubles its digit, adds the carry
// from the cell below and takes off the radix when needed, then hands its
// carry through its token register to the next cell. A carry out of the top
// used cell means the value is not below radix^digit_count: the block then
// gives a single result with digit 0, last_digit and out_of_range set. An
// item is fed into the row bit by bit, its last bit ripples up the row, the
// results are delivered one by one, and only then is the next item taken:
// a new item is taken once the previous item's last result is in the output
// register. Radix values below 2 act as 2, above 256 as 256; a digit count
// of 0 acts as 1, above MAX_DIGITS as MAX_DIGITS. Configuration writes are
// taken in every cycle and must only happen while the block is idle. No
// clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module base_d_digit_split #(
	parameter int MAX_DIGITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdds_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdds_pkg::CFG_DATA_W-1:0]       cfg_data,
	// item channel
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [VALUE_BITS-1:0]                 value,
	// result channel
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [bdds_pkg::DIGIT_W-1:0]          digit,
	output logic                                  last_digit,
	output logic                                  out_of_range
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int BIT_W = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FEED,
		S_WAIT,
		S_EMIT
	} state_t;

	// configuration registers
	logic [bdds_pkg::RADIX_W-1:0] radix_q;
	logic [bdds_pkg::COUNT_W-1:0] count_q;

	// sequencer
	state_t                       state_q;
	logic [VALUE_BITS-1:0]        value_q;
	logic [BIT_W-1:0]             bit_cnt_q;
	logic [bdds_pkg::RADIX_W-1:0] d_eff_q;
	logic [IDX_W-1:0]             n_last_q;
	logic [IDX_W-1:0]             rd_idx_q;
	logic                         ovf_q;
	logic                         err_q;

	// output register
	logic                         res_vld_q;
	logic [bdds_pkg::DIGIT_W-1:0] res_digit_q;
	logic                         res_last_q;
	logic                         res_oor_q;

	// effective configuration
	logic [bdds_pkg::RADIX_W-1:0] d_eff;
	logic [IDX_W-1:0]             n_last;
	logic [bdds_pkg::COUNT_W:0]   cnt_ext;

	// cell row
	bdds_pkg::tok_t               feed_tok;
	bdds_pkg::tok_t               tok_in  [MAX_DIGITS];
	bdds_pkg::tok_t               tok     [MAX_DIGITS];
	logic [bdds_pkg::DIGIT_W-1:0] cell_dig [MAX_DIGITS];
	logic [MAX_DIGITS-1:0]        tok_vld;
	bdds_pkg::tok_t               top_tok;

	logic                         item_acc;
	logic                         res_free;

	// ---------------------------------------------------------------------
	// configuration port: always ready, unknown indexes are dropped
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= bdds_pkg::RADIX_MIN;
			count_q <= bdds_pkg::COUNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				bdds_pkg::CFG_RADIX: radix_q <= cfg_data;
				bdds_pkg::CFG_COUNT: count_q <= cfg_data[bdds_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp radix to 2..256 and digit count to 1..MAX_DIGITS
	always_comb begin
		if (radix_q < bdds_pkg::RADIX_MIN) begin
			d_eff = bdds_pkg::RADIX_MIN;
		end else if (radix_q > bdds_pkg::RADIX_MAX) begin
			d_eff = bdds_pkg::RADIX_MAX;
		end else begin
			d_eff = radix_q;
		end

		cnt_ext = {1'b0, count_q};
		if (count_q == '0) begin
			n_last = '0;
		end else if (cnt_ext > (bdds_pkg::COUNT_W+1)'(MAX_DIGITS)) begin
			n_last = IDX_W'(MAX_DIGITS - 1);
		end else begin
			n_last = IDX_W'(cnt_ext - 1'b1);
		end
	end

	// ---------------------------------------------------------------------
	// cell row
	// ---------------------------------------------------------------------
	// bit stream into the least significant cell, msb first
	always_comb begin
		feed_tok.vld   = (state_q == S_FEED);
		feed_tok.first = (bit_cnt_q == '0);
		feed_tok.last  = (bit_cnt_q == BIT_W'(VALUE_BITS - 1));
		feed_tok.carry = value_q[VALUE_BITS-1];
	end

	generate
		for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_cell
			if (j == 0) begin : g_first
				assign tok_in[j] = feed_tok;
			end else begin : g_next
				// steps stop at the top used cell, nothing runs above it
				always_comb begin
					tok_in[j]     = tok[j-1];
					tok_in[j].vld = tok[j-1].vld & (IDX_W'(j - 1) < n_last_q);
				end
			end

			bdds_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.radix   (d_eff_q),
				.tok_in  (tok_in[j]),
				.tok_out (tok[j]),
				.digit   (cell_dig[j])
			);

			assign tok_vld[j] = tok[j].vld;
		end
	endgenerate

	// the top used cell flags overflow and tells when the value is done
	assign top_tok = tok[n_last_q];

	// ---------------------------------------------------------------------
	// sequencer and output register
	// ---------------------------------------------------------------------
	assign item_ready = (state_q == S_IDLE);
	assign item_acc   = item_valid & item_ready;
	assign res_free   = ~res_vld_q | result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			value_q     <= '0;
			bit_cnt_q   <= '0;
			d_eff_q     <= bdds_pkg::RADIX_MIN;
			n_last_q    <= '0;
			rd_idx_q    <= '0;
			ovf_q       <= 1'b0;
			err_q       <= 1'b0;
			res_vld_q   <= 1'b0;
			res_digit_q <= '0;
			res_last_q  <= 1'b0;
			res_oor_q   <= 1'b0;
		end else begin
			// result taken, while emitting the reload below covers it
			if (res_vld_q && result_ready && (state_q != S_EMIT)) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						value_q   <= value;
						bit_cnt_q <= '0;
						d_eff_q   <= d_eff;
						n_last_q  <= n_last;
						ovf_q     <= 1'b0;
						state_q   <= S_FEED;
					end
				end

				S_FEED: begin
					value_q   <= value_q << 1;
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (top_tok.vld && top_tok.carry) begin
						ovf_q <= 1'b1;
					end
					if (feed_tok.last) begin
						state_q <= S_WAIT;
					end
				end

				S_WAIT: begin
					if (top_tok.vld && top_tok.carry) begin
						ovf_q <= 1'b1;
					end
					if (top_tok.vld && top_tok.last) begin
						err_q    <= ovf_q | top_tok.carry;
						rd_idx_q <= n_last_q;
						state_q  <= S_EMIT;
					end
				end

				S_EMIT: begin
					if (res_free) begin
						res_vld_q <= 1'b1;
						if (err_q) begin
							res_digit_q <= '0;
							res_last_q  <= 1'b1;
							res_oor_q   <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							res_digit_q <= cell_dig[rd_idx_q];
							res_last_q  <= (rd_idx_q == '0);
							res_oor_q   <= 1'b0;
							if (rd_idx_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								rd_idx_q <= rd_idx_q - 1'b1;
							end
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign digit        = res_digit_q;
	assign last_digit   = res_last_q;
	assign out_of_range = res_oor_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	// an error result is a single zero digit that closes the run
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_of_range) |-> (last_digit && (digit == '0)))
		else $error("error result without last_digit or with non-zero digit");

	// the least significant cell holds a proper digit after each step
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok[0].vld |-> (cell_dig[0] < d_eff_q))
		else $error("cell digit not below radix");

	// the row has drained before a new value can be taken
	a_row_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok_vld == '0))
		else $error("steps still in the cell row while idle");

	// the final step reaches the top used cell only while waiting for it
	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(top_tok.vld && top_tok.last) |-> (state_q == S_WAIT))
		else $error("conversion finished outside the wait state");

endmodule
